/* sv/otec_pkg.sv */
package otec_pkg;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_GONE  = 2'd2;

  localparam logic [3:0] REQ_ADD     = 4'd1;
  localparam logic [3:0] REQ_PARTIAL = 4'd2;
  localparam logic [3:0] REQ_DELETE  = 4'd3;
  localparam logic [3:0] REQ_EXEC    = 4'd4;
  localparam logic [3:0] REQ_HIDDEN  = 4'd5;

  localparam logic [3:0] ST_ADD       = 4'd0;
  localparam logic [3:0] ST_CANCEL    = 4'd1;
  localparam logic [3:0] ST_MODIFY    = 4'd2;
  localparam logic [3:0] ST_MISSING   = 4'd3;
  localparam logic [3:0] ST_HIDDEN    = 4'd4;
  localparam logic [3:0] ST_CONTROL   = 4'd5;
  localparam logic [3:0] ST_DUPLICATE = 4'd6;
  localparam logic [3:0] ST_EXCEEDS   = 4'd7;
  localparam logic [3:0] ST_FULL      = 4'd8;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [39:0] order_id;
    logic [31:0] size;
    logic [31:0] price;
    logic [1:0]  direction;
    logic [47:0] timestamp_ns;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [47:0] sequence_res;
    logic [47:0] event_time;
    logic [39:0] event_order;
    logic        event_side;
    logic [31:0] event_price;
    logic [31:0] event_quantity;
  } res_t;

  typedef struct packed {
    logic [1:0]  mark;
    logic [39:0] key;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } entry_t;

endpackage

/* sv/order_table_event_converter.sv */
// Channel  | Ports               | Transfer
// ---------+---------------------+-----------------------------------------
// request  | start, busy, req    | edge with start high and busy low
// result   | done, res           | one cycle with done high, never stalled
//
// An item that needs no table access goes from idle straight to the decide state.
// A table item passes the hashing states HASH1 and HASH2, then probes at most
// PROBE_LIMIT slots and then decides; the single read port of the slot memory
// sets the probe pace.
// After reset a clearing pass marks all TABLE_ENTRIES slots empty, one slot
// a cycle, with busy high. Results cannot be held off. Busy drops in the cycle
// that shows the result, so the next transfer can come at the edge that ends it.
// TABLE_ENTRIES must be a power of two.
module order_table_event_converter
  import otec_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096,
  parameter int PROBE_LIMIT   = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t res
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(PROBE_LIMIT + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_HASH1  = 6'b000100,
    S_HASH2  = 6'b001000,
    S_PROBE  = 6'b010000,
    S_DECIDE = 6'b100000
  } state_t;

  state_t state;
  req_t   req_q;
  logic [AW-1:0] clr_addr;
  logic [43:0]   prod0;
  logic [AW-1:0] base;
  logic [CW-1:0] iss;
  logic [CW-1:0] chk;
  logic          pend;
  logic          found;
  logic [AW-1:0] found_slot;
  entry_t        fent;
  logic          free_ok;
  logic [AW-1:0] free_slot;
  logic [47:0]   next_seq;

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  logic [23:0]   prod1;
  logic [43:0]   hsum;
  logic [AW-1:0] cur_slot;
  logic          hit_empty, hit_key, probe_end, table_op;
  res_t          res_next;
  logic          take_seq;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_addr];
  end

  assign busy     = (state != S_IDLE);
  assign rd_addr  = base + AW'(iss);
  assign cur_slot = base + AW'(chk);
  assign prod1    = 24'(req_q.order_id[39:20] * HASH_MULT[23:0]);
  assign hsum     = prod0 + {prod1, 20'd0};
  assign table_op = (req.direction < 2'd2) &&
                    (req.req_type == REQ_ADD || req.req_type == REQ_PARTIAL ||
                     req.req_type == REQ_DELETE || req.req_type == REQ_EXEC);

  assign hit_empty = (rdata.mark == MARK_EMPTY);
  assign hit_key   = (rdata.mark == MARK_USED) && (rdata.key == req_q.order_id);
  assign probe_end = pend && (hit_empty || hit_key || chk == CW'(PROBE_LIMIT - 1));

  always_comb begin
    res_next             = '0;
    res_next.event_time  = req_q.timestamp_ns;
    res_next.event_order = req_q.order_id;
    res_next.status      = ST_CONTROL;
    we                   = 1'b0;
    wa                   = found_slot;
    wd                   = fent;
    take_seq             = 1'b0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else if (state == S_DECIDE) begin
      priority if (req_q.direction > 2'd1) begin
        res_next.status = ST_CONTROL;
      end else if (req_q.req_type == REQ_ADD) begin
        if (found) begin
          res_next.status = ST_DUPLICATE;
        end else if (!free_ok) begin
          res_next.status = ST_FULL;
        end else begin
          res_next.status         = ST_ADD;
          res_next.event_side     = req_q.direction[0];
          res_next.event_price    = req_q.price;
          res_next.event_quantity = req_q.size;
          take_seq                = 1'b1;
          we                      = 1'b1;
          wa                      = free_slot;
          wd = '{mark: MARK_USED, key: req_q.order_id, side: req_q.direction[0],
                 price: req_q.price, quantity: req_q.size};
        end
      end else if (req_q.req_type == REQ_PARTIAL || req_q.req_type == REQ_EXEC) begin
        if (!found) begin
          res_next.status = ST_MISSING;
        end else if (req_q.size > fent.quantity) begin
          res_next.status = ST_EXCEEDS;
        end else if (req_q.size == fent.quantity) begin
          res_next.status = ST_CANCEL;
          take_seq        = 1'b1;
          we              = 1'b1;
          wd.mark         = MARK_GONE;
        end else begin
          res_next.status         = ST_MODIFY;
          res_next.event_price    = fent.price;
          res_next.event_quantity = fent.quantity - req_q.size;
          take_seq                = 1'b1;
          we                      = 1'b1;
          wd.quantity             = fent.quantity - req_q.size;
        end
      end else if (req_q.req_type == REQ_DELETE) begin
        if (!found) begin
          res_next.status = ST_MISSING;
        end else begin
          res_next.status = ST_CANCEL;
          take_seq        = 1'b1;
          we              = 1'b1;
          wd.mark         = MARK_GONE;
        end
      end else if (req_q.req_type == REQ_HIDDEN) begin
        res_next.status = ST_HIDDEN;
      end else begin
        res_next.status = ST_CONTROL;
      end
      if (take_seq) begin
        res_next.sequence_res = next_seq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      next_seq <= 48'd1;
      iss      <= '0;
      chk      <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
      free_ok  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_q   <= req;
            found   <= 1'b0;
            free_ok <= 1'b0;
            iss     <= '0;
            chk     <= '0;
            pend    <= 1'b0;
            state   <= table_op ? S_HASH1 : S_DECIDE;
          end
        end
        S_HASH1: begin
          prod0 <= 44'(req_q.order_id[19:0] * HASH_MULT[43:0]);
          state <= S_HASH2;
        end
        S_HASH2: begin
          base  <= hsum[24 +: AW];
          state <= S_PROBE;
        end
        S_PROBE: begin
          // Reads run one slot ahead of the checks; reads past the end are dropped.
          if (iss != CW'(PROBE_LIMIT)) begin
            iss  <= iss + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            chk <= chk + 1'b1;
            if (hit_key) begin
              found      <= 1'b1;
              found_slot <= cur_slot;
              fent       <= rdata;
            end
            if (!free_ok && rdata.mark != MARK_USED) begin
              free_ok   <= 1'b1;
              free_slot <= cur_slot;
            end
            if (probe_end) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          res  <= res_next;
          done <= 1'b1;
          if (take_seq) begin
            next_seq <= next_seq + 48'd1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
